FILE: rtl/i2cmrt_pkg.sv
// Package: item types, status codes and command codes for the I2C register transfer sequencer.
`timescale 1ns / 1ps
`default_nettype none
package i2cmrt_pkg;

  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RESTART   = 8'h10;
  localparam logic [7:0] ST_ADDR_ACK  = 8'h18;
  localparam logic [7:0] ST_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_ARB_LOST  = 8'h38;
  localparam logic [7:0] ST_RADDR_ACK = 8'h40;
  localparam logic [7:0] ST_RX_ACKED  = 8'h50;
  localparam logic [7:0] ST_RX_NACKED = 8'h58;

  localparam logic       ACT_START = 1'b0;
  localparam logic       ACT_EVENT = 1'b1;

  localparam logic [1:0] START_NONE  = 2'd0;
  localparam logic [1:0] START_SET   = 2'd1;
  localparam logic [1:0] START_CLEAR = 2'd2;

  localparam logic [1:0] ACK_NONE  = 2'd0;
  localparam logic [1:0] ACK_SET   = 2'd1;
  localparam logic [1:0] ACK_CLEAR = 2'd2;

  localparam logic       REG_DISABLE = 1'b0;

  typedef struct packed {
    logic        action;
    logic [6:0]  dev_addr;
    logic        read_mode;
    logic [7:0]  first_reg;
    logic [15:0] length;
    logic [7:0]  bus_status;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] start_cmd;
    logic       stop_cmd;
    logic [1:0] ack_cmd;
    logic       clear_si;
    logic       dat_valid;
    logic [7:0] dat_out;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       tx_taken;
    logic       done_res;
    logic       failed;
    logic [7:0] error_status;
  } out_item_t;

  typedef struct packed {
    logic       is_read;
    logic [6:0] target_addr;
    logic [7:0] reg_index;
    logic [7:0] error_code;
  } xfer_state_t;

endpackage
`default_nettype wire

FILE: rtl/i2c_master_register_transfer.sv
// Top level: input register, transfer state, result register and configuration port.
// Each accepted item passes through the input register and then the result register.
// Throughput: one item per cycle when the output is not stalled; the state update is a combinational decode.
// Output stall holds the result register and back-pressures through the input register.
// Reset (synchronous, active high) clears disable_cfg, the transfer state and all valids.
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_register_transfer
  import i2cmrt_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire in_item_t    in_item,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      out_item_t   out_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  logic                  disable_cfg;
  logic                  s1_valid;
  in_item_t              s1_item;
  xfer_state_t           state;
  xfer_state_t           state_next;
  logic [COUNT_BITS-1:0] remaining;
  logic [COUNT_BITS-1:0] remaining_next;
  out_item_t             result;
  logic                  advance;
  logic                  accept;
  logic                  fire;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;
  assign fire     = s1_valid && advance;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DISABLE) ? {31'b0, disable_cfg} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      disable_cfg <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DISABLE) begin
      disable_cfg <= pwdata[0];
    end
  end

  i2cmrt_decode #(
    .COUNT_BITS(COUNT_BITS)
  ) u_decode (
    .disable_cfg    (disable_cfg),
    .item           (s1_item),
    .state          (state),
    .remaining      (remaining),
    .result         (result),
    .state_next     (state_next),
    .remaining_next (remaining_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      remaining <= '0;
    end else if (fire) begin
      state     <= state_next;
      remaining <= remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= result;
    end
  end

`ifndef SYNTH
  a_fail_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.failed |-> out_item.done_res)
    else $error("failed result without done");

  a_tx_dat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.tx_taken |-> out_item.dat_valid)
    else $error("write byte taken but not loaded");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room downstream");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |=> $stable(remaining) && $stable(state))
    else $error("state changed with no item");
`endif

endmodule
`default_nettype wire

FILE: rtl/i2cmrt_decode.sv
// Decode of one item into core actions and the next transfer state.
`timescale 1ns / 1ps
`default_nettype none
module i2cmrt_decode
  import i2cmrt_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  disable_cfg,
  input  wire in_item_t              item,
  input  wire xfer_state_t           state,
  input  wire logic [COUNT_BITS-1:0] remaining,
  output      out_item_t             result,
  output      xfer_state_t           state_next,
  output      logic [COUNT_BITS-1:0] remaining_next
);

  localparam int LW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [LW-1:0]         len_ext;
  logic [LW-1:0]         cmax;
  logic [LW-1:0]         len_sat;
  logic [COUNT_BITS-1:0] rem_dec;
  logic [COUNT_BITS-1:0] rem_rx;
  logic [7:0]            addr_w;

  assign len_ext = LW'(item.length);
  assign cmax    = LW'({COUNT_BITS{1'b1}});
  assign len_sat = (len_ext > cmax) ? cmax : len_ext;
  assign rem_dec = remaining - COUNT_BITS'(1);
  assign rem_rx  = (remaining != '0) ? rem_dec : remaining;
  assign addr_w  = {state.target_addr, 1'b0};

  always_comb begin
    result         = '0;
    state_next     = state;
    remaining_next = remaining;
    if (item.action == ACT_START) begin
      if (disable_cfg) begin
        result.done_res = 1'b1;
        result.failed   = 1'b1;
      end else begin
        state_next.target_addr = item.dev_addr;
        state_next.is_read     = item.read_mode;
        state_next.reg_index   = item.first_reg;
        state_next.error_code  = '0;
        remaining_next         = len_sat[COUNT_BITS-1:0];
        result.start_cmd       = START_SET;
      end
    end else begin
      case (item.bus_status)
        ST_START: begin
          result.dat_valid = 1'b1;
          result.dat_out   = addr_w;
          result.clear_si  = 1'b1;
        end
        ST_RESTART: begin
          result.dat_valid = 1'b1;
          result.dat_out   = addr_w | 8'h01;
          result.clear_si  = 1'b1;
        end
        ST_ADDR_ACK: begin
          result.start_cmd = START_CLEAR;
          result.clear_si  = 1'b1;
          if (remaining == '0) begin
            result.stop_cmd = 1'b1;
            result.done_res = 1'b1;
          end else begin
            result.dat_valid = 1'b1;
            result.dat_out   = state.reg_index;
          end
        end
        ST_DATA_ACK: begin
          result.clear_si = 1'b1;
          if (state.is_read) begin
            result.start_cmd = START_SET;
          end else if (remaining == '0) begin
            result.start_cmd = START_CLEAR;
            result.stop_cmd  = 1'b1;
            result.done_res  = 1'b1;
          end else begin
            result.dat_valid = 1'b1;
            result.dat_out   = item.tx_byte;
            result.tx_taken  = 1'b1;
            remaining_next   = rem_dec;
          end
        end
        ST_RADDR_ACK: begin
          result.start_cmd = START_CLEAR;
          result.ack_cmd   = (remaining > COUNT_BITS'(1)) ? ACK_SET : ACK_CLEAR;
          result.clear_si  = 1'b1;
        end
        ST_RX_ACKED: begin
          result.rx_valid = 1'b1;
          result.rx_data  = item.rx_byte;
          remaining_next  = rem_rx;
          result.ack_cmd  = (rem_rx <= COUNT_BITS'(1)) ? ACK_CLEAR : ACK_SET;
          result.clear_si = 1'b1;
        end
        ST_RX_NACKED: begin
          result.rx_valid  = 1'b1;
          result.rx_data   = item.rx_byte;
          result.start_cmd = START_CLEAR;
          result.stop_cmd  = 1'b1;
          result.clear_si  = 1'b1;
          result.done_res  = 1'b1;
        end
        ST_ARB_LOST: begin
          state_next.error_code = item.bus_status;
          result.done_res       = 1'b1;
          result.failed         = 1'b1;
          result.error_status   = item.bus_status;
        end
        default: begin
          state_next.error_code = item.bus_status;
          result.start_cmd      = START_CLEAR;
          result.stop_cmd       = 1'b1;
          result.clear_si       = 1'b1;
          result.done_res       = 1'b1;
          result.failed         = 1'b1;
          result.error_status   = item.bus_status;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb_i2c_master_register_transfer.sv
// Testbench: directed and random transfers for the I2C register transfer sequencer.
`timescale 1ns / 1ps
module tb_i2c_master_register_transfer;
  import i2cmrt_pkg::*;

  localparam logic [7:0] ST_BUS_ERROR  = 8'h00;
  localparam logic [7:0] ST_ADDR_NACK  = 8'h20;
  localparam logic [7:0] ST_DATA_NACK  = 8'h30;
  localparam logic [7:0] ST_RADDR_NACK = 8'h48;
  localparam int MAX_BURST = 12;

  typedef struct {
    bit         is_cfg;
    bit         cfg_val;
    in_item_t   item;
    bit         has_lit;
    out_item_t  lit;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic        in_lit_valid;
  out_item_t   in_lit;

  logic        seq_disabled;
  logic        seq_is_read;
  logic [6:0]  seq_addr;
  logic [7:0]  seq_reg;
  logic [15:0] seq_left;
  logic [7:0]  seq_err;

  out_item_t   pending_actions[$];
  dir_row_t    directed_rows[$];
  int          err_count;
  int          sent_count;
  bit          no_idle;
  bit          hold_req;
  int          hold_left;

  i2c_master_register_transfer uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic out_item_t with_stop(out_item_t r);
    r.start_cmd = START_CLEAR;
    r.stop_cmd  = 1'b1;
    r.clear_si  = 1'b1;
    r.done_res  = 1'b1;
    return r;
  endfunction

  function automatic out_item_t next_core_actions(in_item_t it);
    out_item_t  r;
    logic [7:0] addr_w;
    r = '0;
    if (it.action == ACT_START) begin
      if (seq_disabled) begin
        r.done_res = 1'b1;
        r.failed   = 1'b1;
      end else begin
        seq_addr    = it.dev_addr;
        seq_is_read = it.read_mode;
        seq_reg     = it.first_reg;
        seq_left    = it.length;
        seq_err     = '0;
        r.start_cmd = START_SET;
      end
    end else begin
      addr_w = {seq_addr, 1'b0};
      case (it.bus_status)
        ST_START: begin
          r.dat_valid = 1'b1;
          r.dat_out   = addr_w;
          r.clear_si  = 1'b1;
        end
        ST_RESTART: begin
          r.dat_valid = 1'b1;
          r.dat_out   = addr_w | 8'd1;
          r.clear_si  = 1'b1;
        end
        ST_ADDR_ACK: begin
          if (seq_left == 0) begin
            r = with_stop(r);
          end else begin
            r.start_cmd = START_CLEAR;
            r.dat_valid = 1'b1;
            r.dat_out   = seq_reg;
            r.clear_si  = 1'b1;
          end
        end
        ST_DATA_ACK: begin
          if (seq_is_read) begin
            r.start_cmd = START_SET;
            r.clear_si  = 1'b1;
          end else if (seq_left == 0) begin
            r = with_stop(r);
          end else begin
            r.dat_valid = 1'b1;
            r.dat_out   = it.tx_byte;
            r.tx_taken  = 1'b1;
            r.clear_si  = 1'b1;
            seq_left    = seq_left - 16'd1;
          end
        end
        ST_RADDR_ACK: begin
          r.start_cmd = START_CLEAR;
          r.ack_cmd   = (seq_left > 1) ? ACK_SET : ACK_CLEAR;
          r.clear_si  = 1'b1;
        end
        ST_RX_ACKED: begin
          r.rx_valid = 1'b1;
          r.rx_data  = it.rx_byte;
          if (seq_left != 0) seq_left = seq_left - 16'd1;
          r.ack_cmd  = (seq_left <= 1) ? ACK_CLEAR : ACK_SET;
          r.clear_si = 1'b1;
        end
        ST_RX_NACKED: begin
          r.rx_valid = 1'b1;
          r.rx_data  = it.rx_byte;
          r = with_stop(r);
        end
        ST_ARB_LOST: begin
          seq_err        = it.bus_status;
          r.done_res     = 1'b1;
          r.failed       = 1'b1;
          r.error_status = it.bus_status;
        end
        default: begin
          seq_err        = it.bus_status;
          r = with_stop(r);
          r.failed       = 1'b1;
          r.error_status = it.bus_status;
        end
      endcase
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_actions.size() == 0) begin
          err_count++;
          $display("%0t: item with nothing expected, expected none, actual %h",
                   $time, out_item);
        end else begin
          want = pending_actions.pop_front();
          check_field("start_cmd", 8'(want.start_cmd), 8'(out_item.start_cmd));
          check_field("stop_cmd", 8'(want.stop_cmd), 8'(out_item.stop_cmd));
          check_field("ack_cmd", 8'(want.ack_cmd), 8'(out_item.ack_cmd));
          check_field("clear_si", 8'(want.clear_si), 8'(out_item.clear_si));
          check_field("dat_valid", 8'(want.dat_valid), 8'(out_item.dat_valid));
          check_field("dat_out", want.dat_out, out_item.dat_out);
          check_field("rx_valid", 8'(want.rx_valid), 8'(out_item.rx_valid));
          check_field("rx_data", want.rx_data, out_item.rx_data);
          check_field("tx_taken", 8'(want.tx_taken), 8'(out_item.tx_taken));
          check_field("done_res", 8'(want.done_res), 8'(out_item.done_res));
          check_field("failed", 8'(want.failed), 8'(out_item.failed));
          check_field("error_status", want.error_status, out_item.error_status);
        end
      end
      if (in_valid && !in_stall) begin
        want = next_core_actions(in_item);
        pending_actions.push_back(in_lit_valid ? in_lit : want);
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 33);
      end
    end
  end

  function automatic in_item_t rand_item();
    logic [63:0] raw;
    in_item_t    it;
    raw = {$urandom, $urandom};
    it  = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic in_item_t mk_start(logic [6:0] addr, logic rd, logic [7:0] first,
                                        logic [15:0] len);
    in_item_t it;
    it           = rand_item();
    it.action    = ACT_START;
    it.dev_addr  = addr;
    it.read_mode = rd;
    it.first_reg = first;
    it.length    = len;
    return it;
  endfunction

  function automatic in_item_t mk_event(logic [7:0] st, logic [7:0] rx, logic [7:0] tx);
    in_item_t it;
    it            = rand_item();
    it.action     = ACT_EVENT;
    it.bus_status = st;
    it.rx_byte    = rx;
    it.tx_byte    = tx;
    return it;
  endfunction

  function automatic out_item_t acts(logic [1:0] st, logic sp, logic [1:0] ak, logic cs,
                                     logic dv, logic [7:0] dat, logic done, logic fail,
                                     logic [7:0] err);
    out_item_t r;
    r              = '0;
    r.start_cmd    = st;
    r.stop_cmd     = sp;
    r.ack_cmd      = ak;
    r.clear_si     = cs;
    r.dat_valid    = dv;
    r.dat_out      = dat;
    r.done_res     = done;
    r.failed       = fail;
    r.error_status = err;
    return r;
  endfunction

  function automatic void add_row(in_item_t it, bit has_lit, out_item_t lit);
    dir_row_t row;
    row.is_cfg  = 1'b0;
    row.cfg_val = 1'b0;
    row.item    = it;
    row.has_lit = has_lit;
    row.lit     = lit;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(bit v);
    dir_row_t row;
    row         = '{default: '0};
    row.is_cfg  = 1'b1;
    row.cfg_val = v;
    directed_rows.push_back(row);
  endfunction

  task automatic send(in_item_t it, bit has_lit, out_item_t lit);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_item      <= it;
    in_lit_valid <= has_lit;
    in_lit       <= lit;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(bit v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_DISABLE, 2'b00};
    pwdata  <= {31'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    seq_disabled = v;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] bus_fault_code();
    case ($urandom_range(5))
      0: return ST_BUS_ERROR;
      1: return ST_ADDR_NACK;
      2: return ST_DATA_NACK;
      3: return ST_RADDR_NACK;
      4: return ST_ARB_LOST;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_transfer();
    logic [15:0] len;
    bit          rd;
    int          n_data;
    int          keep;
    int          pick;
    logic [7:0]  statuses[$];
    pick = $urandom_range(99);
    if (pick < 8) len = 16'd0;
    else if (pick < 80) len = 16'($urandom_range(6, 1));
    else if (pick < 92) len = 16'($urandom_range(20, 7));
    else len = 16'($urandom_range(65535));
    rd = 1'($urandom_range(1));
    send(mk_start(7'($urandom), rd, 8'($urandom), len), 1'b0, '0);
    n_data = (len > MAX_BURST) ? MAX_BURST : len;
    statuses.push_back(ST_START);
    statuses.push_back(ST_ADDR_ACK);
    if (len != 0) begin
      if (!rd) begin
        repeat (n_data) statuses.push_back(ST_DATA_ACK);
        if (len <= MAX_BURST) statuses.push_back(ST_DATA_ACK);
      end else begin
        statuses.push_back(ST_DATA_ACK);
        statuses.push_back(ST_RESTART);
        statuses.push_back(ST_RADDR_ACK);
        repeat (n_data - 1) statuses.push_back(ST_RX_ACKED);
        if (len <= MAX_BURST) statuses.push_back(ST_RX_NACKED);
      end
    end
    if ($urandom_range(99) < 10) begin
      keep = $urandom_range(statuses.size() - 1);
      while (statuses.size() > keep) void'(statuses.pop_back());
      if ($urandom_range(3) != 0) statuses.push_back(bus_fault_code());
    end else if (len > MAX_BURST && $urandom_range(3) != 0) begin
      statuses.push_back(bus_fault_code());
    end
    foreach (statuses[i]) send(mk_event(statuses[i], 8'($urandom), 8'($urandom)), 1'b0, '0);
    if ($urandom_range(99) < 3) wait_drained();
  endtask

  task automatic run_traffic(int n);
    int stop_at;
    stop_at = sent_count + n;
    while (sent_count < stop_at) begin
      if ($urandom_range(99) < 85) send_transfer();
      else send(rand_item(), 1'b0, '0);
    end
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_item      = '0;
    in_lit_valid = 1'b0;
    in_lit       = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    err_count    = 0;
    sent_count   = 0;
    no_idle      = 1'b0;
    hold_req     = 1'b0;
    seq_disabled = 1'b0;
    seq_is_read  = 1'b0;
    seq_addr     = '0;
    seq_reg      = '0;
    seq_left     = '0;
    seq_err      = '0;

    add_row(mk_event(ST_START, 8'h00, 8'h00), 1,
            acts(START_NONE, 0, ACK_NONE, 1, 1, 8'h00, 0, 0, 8'h00));
    add_row(mk_event(ST_ADDR_ACK, 8'hFF, 8'hFF), 1,
            acts(START_CLEAR, 1, ACK_NONE, 1, 0, 8'h00, 1, 0, 8'h00));
    add_row(mk_event(ST_BUS_ERROR, 8'h00, 8'hFF), 1,
            acts(START_CLEAR, 1, ACK_NONE, 1, 0, 8'h00, 1, 1, ST_BUS_ERROR));
    add_row(mk_event(8'hFF, 8'hFF, 8'h00), 1,
            acts(START_CLEAR, 1, ACK_NONE, 1, 0, 8'h00, 1, 1, 8'hFF));
    add_row(mk_event(ST_ARB_LOST, 8'h5A, 8'hA5), 1,
            acts(START_NONE, 0, ACK_NONE, 0, 0, 8'h00, 1, 1, ST_ARB_LOST));
    add_row(mk_start(7'h7F, 1'b0, 8'hFF, 16'd2), 1,
            acts(START_SET, 0, ACK_NONE, 0, 0, 8'h00, 0, 0, 8'h00));
    add_row(mk_event(ST_START, 8'h00, 8'h00), 1,
            acts(START_NONE, 0, ACK_NONE, 1, 1, 8'hFE, 0, 0, 8'h00));
    add_row(mk_event(ST_ADDR_ACK, 8'h00, 8'h00), 0, '0);
    add_row(mk_event(ST_DATA_ACK, 8'h00, 8'hFF), 0, '0);
    add_row(mk_event(ST_DATA_ACK, 8'hFF, 8'h00), 0, '0);
    add_row(mk_event(ST_DATA_ACK, 8'h00, 8'h3C), 0, '0);
    add_row(mk_start(7'h55, 1'b1, 8'h00, 16'd3), 0, '0);
    add_row(mk_event(ST_START, 8'h00, 8'h00), 0, '0);
    add_row(mk_event(ST_ADDR_ACK, 8'h00, 8'h00), 0, '0);
    add_row(mk_event(ST_DATA_ACK, 8'h00, 8'h00), 0, '0);
    add_row(mk_event(ST_RESTART, 8'h00, 8'h00), 0, '0);
    add_row(mk_event(ST_RADDR_ACK, 8'h00, 8'h00), 0, '0);
    add_row(mk_event(ST_RX_ACKED, 8'hFF, 8'h00), 0, '0);
    add_row(mk_event(ST_RX_ACKED, 8'h00, 8'hFF), 0, '0);
    add_row(mk_event(ST_RX_ACKED, 8'h81, 8'h00), 0, '0);
    add_row(mk_event(ST_RX_ACKED, 8'h7E, 8'h00), 0, '0);
    add_row(mk_event(ST_RX_NACKED, 8'hA5, 8'h00), 0, '0);
    add_row(mk_start(7'h2A, 1'b1, 8'h80, 16'd0), 0, '0);
    add_row(mk_event(ST_ADDR_ACK, 8'h00, 8'h00), 0, '0);
    add_row(mk_start(7'h00, 1'b0, 8'h01, 16'hFFFF), 0, '0);
    add_row(mk_event(ST_RADDR_ACK, 8'h00, 8'h00), 0, '0);
    add_cfg(1'b1);
    add_row(mk_start(7'h7F, 1'b1, 8'hFF, 16'hFFFF), 1,
            acts(START_NONE, 0, ACK_NONE, 0, 0, 8'h00, 1, 1, 8'h00));
    add_row(mk_event(ST_START, 8'h00, 8'h00), 0, '0);
    add_cfg(1'b0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    cfg_write(1'b0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_drained();
        cfg_write(directed_rows[i].cfg_val);
      end else begin
        send(directed_rows[i].item, directed_rows[i].has_lit, directed_rows[i].lit);
      end
    end

    run_traffic(100);
    hold_req = 1'b1;
    run_traffic(100);
    wait_drained();
    cfg_write(1'b1);
    run_traffic(60);
    wait_drained();
    cfg_write(1'b0);
    no_idle = 1'b1;
    run_traffic(150);
    wait_drained();
    no_idle = 1'b0;
    cfg_write(1'b1);
    run_traffic(40);
    wait_drained();
    cfg_write(1'b0);
    run_traffic(150);
    wait_drained();
    repeat (10) @(posedge clk);

    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: i2c_master_register_transfer.f
rtl/i2cmrt_pkg.sv
rtl/i2cmrt_decode.sv
rtl/i2c_master_register_transfer.sv
tb/tb_i2c_master_register_transfer.sv
